### rtl/tgr_pkg.sv
// Shared types, constants and the microcode ROM for the text glyph renderer.
// No dependencies; imported by every module of the block except tgr_ram.
package tgr_pkg;

   localparam int DEF_GLYPH_WIDTH  = 8;
   localparam int DEF_GLYPH_HEIGHT = 16;
   localparam int DEF_GLYPH_COUNT  = 96;

   localparam logic [7:0] CHAR_FIRST   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam int         TAB_SPACES   = 4;

   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FORE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 2'd2;

   localparam logic [23:0] FORE_RESET  = 24'hFFFFFF;
   localparam logic [23:0] BACK_RESET  = 24'h000000;
   localparam logic [11:0] WIDTH_RESET = 12'd1024;

   typedef struct packed {
      logic        op;
      logic [7:0]  char_code;
      logic [10:0] font_address;
      logic [7:0]  font_byte;
   } req_data_type;

   typedef struct packed {
      logic [12:0] pixel_x;
      logic [15:0] pixel_y;
      logic [7:0]  row_bits;
      logic [23:0] fg_color;
      logic [23:0] bg_color;
      logic        last;
   } rsp_data_type;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_WRITE,
      CLS_NEWLINE,
      CLS_GLYPH
   } item_class_type;

   typedef enum logic [2:0] {
      UOP_NOP,
      UOP_FONT_WR,
      UOP_NEWLINE,
      UOP_ROW,
      UOP_ADVANCE
   } uop_type;

   typedef enum logic [1:0] {
      COND_GOTO,
      COND_REQ,
      COND_ROW_MORE,
      COND_REP_MORE
   } cond_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_WAIT    = 3'd0;
   localparam step_type STEP_WRITE   = 3'd1;
   localparam step_type STEP_NEWLINE = 3'd2;
   localparam step_type STEP_ROW     = 3'd3;
   localparam step_type STEP_ADVANCE = 3'd4;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      step_type jmp_t;
      step_type jmp_f;
   } ucode_type;

   typedef struct packed {
      logic    accept;
      uop_type op;
   } seq_ctrl_type;

   typedef struct packed {
      item_class_type cls;
      logic           row_final;
      logic           rep_more;
      logic           slot_free;
   } dp_status_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type cw;
      case (step)
         STEP_WAIT:    cw = '{UOP_NOP,     COND_REQ,      STEP_WAIT, STEP_WAIT};
         STEP_WRITE:   cw = '{UOP_FONT_WR, COND_GOTO,     STEP_WAIT, STEP_WAIT};
         STEP_NEWLINE: cw = '{UOP_NEWLINE, COND_GOTO,     STEP_WAIT, STEP_WAIT};
         STEP_ROW:     cw = '{UOP_ROW,     COND_ROW_MORE, STEP_ROW,  STEP_ADVANCE};
         STEP_ADVANCE: cw = '{UOP_ADVANCE, COND_REP_MORE, STEP_ROW,  STEP_WAIT};
         default:      cw = '{UOP_NOP,     COND_GOTO,     STEP_WAIT, STEP_WAIT};
      endcase
      return cw;
   endfunction

   function automatic logic [15:0] sat_row(input logic [16:0] sum);
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

endpackage

### rtl/tgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tgr_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1536
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                      wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                      rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tgr_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup, item dispatch and jumps.
// Depends on tgr_pkg.
module tgr_sequencer import tgr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output seq_ctrl_type  ctrl
);

   step_type  pc_ff;
   step_type  pc_in;
   ucode_type cw;
   logic      taken;
   logic      hold;
   step_type  target;
   step_type  dispatch;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      cw   = ucode_rom(pc_ff);
      hold = (cw.op == UOP_ROW) && !status.slot_free;

      case (status.cls)
         CLS_WRITE:   dispatch = STEP_WRITE;
         CLS_NEWLINE: dispatch = STEP_NEWLINE;
         CLS_GLYPH:   dispatch = STEP_ROW;
         default:     dispatch = STEP_WAIT;
      endcase

      case (cw.cond)
         COND_GOTO:     taken = 1'b1;
         COND_REQ:      taken = req_valid;
         COND_ROW_MORE: taken = !status.row_final;
         COND_REP_MORE: taken = status.rep_more;
         default:       taken = 1'b0;
      endcase

      if (cw.cond == COND_REQ && taken) begin
         target = dispatch;
      end else if (taken) begin
         target = cw.jmp_t;
      end else begin
         target = cw.jmp_f;
      end

      pc_in       = hold ? pc_ff : target;
      req_stall   = (cw.cond != COND_REQ);
      ctrl.accept = (cw.cond == COND_REQ) && req_valid;
      ctrl.op     = hold ? UOP_NOP : cw.op;
   end

endmodule

### rtl/tgr_datapath.sv
// Datapath: config registers, cursor, glyph row addressing, font store and
// the two-stage result pipe. Depends on tgr_pkg and tgr_ram.
module tgr_datapath import tgr_pkg::*; #(
   parameter int GLYPH_WIDTH  = DEF_GLYPH_WIDTH,
   parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT,
   parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_data_type          req_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  seq_ctrl_type          ctrl,
   output dp_status_type         status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data
);

   localparam int STORE_SIZE = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int ROW_W      = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
   localparam int BIT_SHIFT  = 8 - GLYPH_WIDTH;
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_HEIGHT - 1);
   localparam logic [1:0]       TAB_REP  = 2'(TAB_SPACES - 1);

   logic [23:0]       fore_ff, back_ff;
   logic [11:0]       width_ff;
   logic [12:0]       col_ff, col_in;
   logic [15:0]       crow_ff, crow_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] raddr_ff, raddr_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [1:0]        rep_ff, rep_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [7:0]        wr_byte_ff, wr_byte_in;
   logic              wr_ok_ff, wr_ok_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [12:0]       s1_x_ff, s1_x_in;
   logic [15:0]       s1_y_ff, s1_y_in;
   logic              s1_last_ff, s1_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_data_type      rsp_data_ff, rsp_data_in;

   logic [7:0]        code_ofs;
   logic              is_print, is_tab;
   logic [7:0]        glyph_sel;
   logic              row_final, s1_move, slot_free, issue;
   logic [12:0]       col_sum;
   logic [15:0]       crow_next_line;
   logic [7:0]        rd_data;
   logic              ram_wr_en;

   // Item classification
   always_comb begin
      code_ofs  = req_data.char_code - CHAR_FIRST;
      is_tab    = (req_data.char_code == CHAR_TAB);
      is_print  = (req_data.char_code >= CHAR_FIRST) && (int'(code_ofs) < GLYPH_COUNT);
      glyph_sel = is_tab ? 8'd0 : code_ofs;
      if (req_data.op) begin
         status.cls = CLS_WRITE;
      end else if (req_data.char_code == CHAR_NEWLINE) begin
         status.cls = CLS_NEWLINE;
      end else if (is_tab || is_print) begin
         status.cls = CLS_GLYPH;
      end else begin
         status.cls = CLS_NONE;
      end
      status.row_final = row_final;
      status.rep_more  = (rep_ff != 2'd0);
      status.slot_free = slot_free;
   end

   assign row_final        = (row_ff == ROW_LAST);
   assign s1_move          = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign slot_free        = !s1_valid_ff || s1_move;
   assign issue            = (ctrl.op == UOP_ROW);

   assign col_sum        = col_ff + 13'(GLYPH_WIDTH);
   assign crow_next_line = sat_row({1'b0, crow_ff} + 17'(GLYPH_HEIGHT));
   assign ram_wr_en      = (ctrl.op == UOP_FONT_WR) && wr_ok_ff;

   always_comb begin
      col_in      = col_ff;
      crow_in     = crow_ff;
      base_in     = base_ff;
      raddr_in    = raddr_ff;
      row_in      = row_ff;
      rep_in      = rep_ff;
      wr_addr_in  = wr_addr_ff;
      wr_byte_in  = wr_byte_ff;
      wr_ok_in    = wr_ok_ff;
      s1_x_in     = s1_x_ff;
      s1_y_in     = s1_y_ff;
      s1_last_in  = s1_last_ff;
      s1_valid_in = s1_move ? 1'b0 : s1_valid_ff;

      if (ctrl.accept) begin
         base_in    = ADDR_W'(int'(glyph_sel) * GLYPH_HEIGHT);
         raddr_in   = ADDR_W'(int'(glyph_sel) * GLYPH_HEIGHT);
         row_in     = '0;
         rep_in     = is_tab ? TAB_REP : 2'd0;
         wr_addr_in = ADDR_W'(req_data.font_address);
         wr_byte_in = req_data.font_byte;
         wr_ok_in   = (int'(req_data.font_address) < STORE_SIZE);
      end

      case (ctrl.op)
         UOP_NEWLINE: begin
            col_in  = '0;
            crow_in = crow_next_line;
         end
         UOP_ROW: begin
            s1_valid_in = 1'b1;
            s1_x_in     = col_ff;
            s1_y_in     = sat_row({1'b0, crow_ff} + 17'(row_ff));
            s1_last_in  = row_final && (rep_ff == 2'd0);
            raddr_in    = raddr_ff + ADDR_W'(1);
            row_in      = row_final ? '0 : row_ff + ROW_W'(1);
         end
         UOP_ADVANCE: begin
            if (col_sum > {1'b0, width_ff}) begin
               col_in  = '0;
               crow_in = crow_next_line;
            end else begin
               col_in = col_sum;
            end
            raddr_in = base_ff;
            if (rep_ff != 2'd0) begin
               rep_in = rep_ff - 2'd1;
            end
         end
         default: begin
         end
      endcase

      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_data_in = rsp_data_ff;
      if (s1_move) begin
         rsp_data_in.pixel_x  = s1_x_ff;
         rsp_data_in.pixel_y  = s1_y_ff;
         rsp_data_in.row_bits = 8'(rd_data << BIT_SHIFT);
         rsp_data_in.fg_color = fore_ff;
         rsp_data_in.bg_color = back_ff;
         rsp_data_in.last     = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fore_ff      <= FORE_RESET;
         back_ff      <= BACK_RESET;
         width_ff     <= WIDTH_RESET;
         col_ff       <= '0;
         crow_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FORE:  fore_ff  <= csr_data[23:0];
               CSR_BACK:  back_ff  <= csr_data[23:0];
               CSR_WIDTH: width_ff <= csr_data[11:0];
               default: begin
               end
            endcase
         end
         col_ff       <= col_in;
         crow_ff      <= crow_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      raddr_ff    <= raddr_in;
      row_ff      <= row_in;
      rep_ff      <= rep_in;
      wr_addr_ff  <= wr_addr_in;
      wr_byte_ff  <= wr_byte_in;
      wr_ok_ff    <= wr_ok_in;
      s1_x_ff     <= s1_x_in;
      s1_y_ff     <= s1_y_in;
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   tgr_ram #(
      .DATA_W (8),
      .DEPTH  (STORE_SIZE)
   ) u_font_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_byte_ff),
      .rd_en   (issue),
      .rd_addr (raddr_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/text_glyph_renderer.sv
// Top level of the text glyph renderer: microcode sequencer plus datapath.
// Depends on tgr_pkg, tgr_sequencer, tgr_datapath (and tgr_ram below it).
//
//   channel | direction | ports                          | one transaction
//   req     | in        | req_valid, req_stall, req_data | render code or font byte write
//   rsp     | out       | rsp_valid, rsp_stall, rsp_data | one glyph row
//   csr     | in        | csr_wr_en, csr_index, csr_data | one register write
//
// Printable code: accept, a ROW step per glyph row, then ADVANCE; a tab runs these
// four times. Newline, font write: accept, then their step; others: accept only.
// The single font store read port sets the one-row-per-cycle pace; rows pass the
// font store output and stage 1 registers to rsp_data. rsp_stall holds the row step.
// Reset is synchronous: cursor to 0, colors and width to defaults; the font
// store is not cleared and must be loaded before use.
module text_glyph_renderer import tgr_pkg::*; #(
   parameter int GLYPH_WIDTH  = DEF_GLYPH_WIDTH,
   parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT,
   parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   seq_ctrl_type  ctrl;
   dp_status_type status;

   tgr_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   tgr_datapath #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT),
      .GLYPH_COUNT  (GLYPH_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctrl      (ctrl),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
